// ===== src/radix2_fft_engine_top_defines.svh =====
// assertion macros for the radix-2 fft engine
// used by radix2_fft_engine_top; needs a clk and rst in the including scope
`ifndef RADIX2_FFT_ENGINE_TOP_DEFINES_SVH
`define RADIX2_FFT_ENGINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fft engine assertion failed");
`define FFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fft engine assertion failed");
`else
`define FFT_ASSERT_SAME(lbl, ante, cons)
`define FFT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/r2fft_pkg.sv =====
// shared types, constants and twiddle table for the radix-2 fft engine
// no dependencies
package r2fft_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int LOG2_MAX   = 10;
  localparam int ADDR_W     = 10;
  localparam int DATA_W     = 28;
  localparam int SAMPLE_W   = 16;
  localparam int TW_W       = 16;
  localparam int TW_DEPTH   = MAX_POINTS / 2;
  localparam int TW_ADDR_W  = ADDR_W - 1;
  localparam int PROD_W     = DATA_W + TW_W;
  localparam real PI        = 3.14159265358979323846;
  // angle between neighbouring twiddle entries
  localparam real TW_STEP   = 2.0 * PI / real'(MAX_POINTS);

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  typedef logic signed [TW_W-1:0] tw_rom_t [TW_DEPTH];

  // round half away from zero, saturate at just below +1.0
  function automatic logic signed [TW_W-1:0] tw_quant(input real v);
    real a;
    int  m;
    a = (v < 0.0) ? -v : v;
    m = $rtoi(a * real'(1 << (TW_W - 1)) + 0.5);
    if (m > (1 << (TW_W - 1)) - 1) m = (1 << (TW_W - 1)) - 1;
    if (v < 0.0) m = -m;
    return TW_W'(m);
  endfunction

  // cos(2*pi*k/N)
  function automatic tw_rom_t build_tw_re();
    tw_rom_t r;
    for (int k = 0; k < TW_DEPTH; k++)
      r[k] = tw_quant($cos(TW_STEP * real'(k)));
    return r;
  endfunction

  // -sin(2*pi*k/N)
  function automatic tw_rom_t build_tw_im();
    tw_rom_t r;
    for (int k = 0; k < TW_DEPTH; k++)
      r[k] = -tw_quant($sin(TW_STEP * real'(k)));
    return r;
  endfunction

endpackage

// ===== src/radix2_fft_engine_top.sv =====
// top level of the in-place radix-2 decimation-in-time fft engine
// depends on r2fft_pkg, r2fft_bfly and radix2_fft_engine_top_defines.svh
//
//  channel   direction  handshake            payload
//  request   in         start, busy          req_type, index, sample_real, sample_imag
//  result    out        bin_valid strobe     bin_index, bin_real, bin_imag
//  config    in         log2_we              log2_wdata
//
// a write is stored when accepted; a read returns its bin in the cycle after the
// request. a run holds busy for the bit-reversal scan (each index read, each
// swapped pair read and written back) and (N/2)*log2 N butterflies, each read,
// multiplied, added and written back via the sample memory's read and write port.
// reset clears control only; memory content is undefined until written.
// the receiver cannot stall; every result appears for exactly one cycle.
`include "radix2_fft_engine_top_defines.svh"

module radix2_fft_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [9:0]  index,
  input  logic signed [15:0] sample_real,
  input  logic signed [15:0] sample_imag,
  input  logic        log2_we,
  input  logic [3:0]  log2_wdata,
  output logic        bin_valid,
  output logic [9:0]  bin_index,
  output logic signed [27:0] bin_real,
  output logic signed [27:0] bin_imag
);

  localparam int AW = r2fft_pkg::ADDR_W;
  localparam r2fft_pkg::tw_rom_t TW_RE = r2fft_pkg::build_tw_re();
  localparam r2fft_pkg::tw_rom_t TW_IM = r2fft_pkg::build_tw_im();

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SW_RDI = 10'b0000000010,
    S_SW_RDR = 10'b0000000100,
    S_SW_WRI = 10'b0000001000,
    S_SW_WRR = 10'b0000010000,
    S_BF_RDP = 10'b0000100000,
    S_BF_RDQ = 10'b0001000000,
    S_BF_MUL = 10'b0010000000,
    S_BF_ADD = 10'b0100000000,
    S_BF_WRQ = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [3:0]    log2_points;
  logic [3:0]    len_l;
  logic [AW-1:0] pos, pos_next;
  logic [AW-2:0] bfc, bfc_next;
  logic [3:0]    stage, stage_next;

  r2fft_pkg::cplx_t mem [r2fft_pkg::MAX_POINTS];
  r2fft_pkg::cplx_t rd_q, hold, u_reg, b_reg, wr_data, bf_a, bf_b;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  logic signed [r2fft_pkg::TW_W-1:0] tw_re_q, tw_im_q;

  logic          accept;
  logic [3:0]    eff_l;
  logic [AW-1:0] rev_full, rev, last_pos, half, half_mask, c_ext, j, p_addr, q_addr;
  logic [AW-1:0] tw_full;
  logic [AW-2:0] last_bfc;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // clamp the configured length
  always_comb begin
    if (log2_points < 4'd1) eff_l = 4'd1;
    else if (log2_points > 4'(r2fft_pkg::LOG2_MAX)) eff_l = 4'(r2fft_pkg::LOG2_MAX);
    else eff_l = log2_points;
  end

  // address generation for the reversal scan and butterflies
  always_comb begin
    for (int k = 0; k < AW; k++) rev_full[k] = pos[AW-1-k];
    rev       = rev_full >> (4'(AW) - len_l);
    last_pos  = AW'((11'd1 << len_l) - 11'd1);
    last_bfc  = (AW-1)'(((11'd1 << len_l) >> 1) - 11'd1);
    half      = AW'(1) << (stage - 4'd1);
    half_mask = half - AW'(1);
    c_ext     = {1'b0, bfc};
    j         = c_ext & half_mask;
    p_addr    = ((c_ext & ~half_mask) << 1) | j;
    q_addr    = p_addr | half;
    tw_full   = j << (4'(AW) - stage);
  end

  // sequencer
  always_comb begin
    state_next = state;
    pos_next   = pos;
    bfc_next   = bfc;
    stage_next = stage;
    rd_addr    = index;
    wr_en      = 1'b0;
    wr_addr    = index;
    wr_data.re = {{(r2fft_pkg::DATA_W-16){sample_real[15]}}, sample_real};
    wr_data.im = {{(r2fft_pkg::DATA_W-16){sample_imag[15]}}, sample_imag};
    case (state)
      S_IDLE: begin
        if (accept && req_type == r2fft_pkg::REQ_WRITE) wr_en = 1'b1;
        if (accept && req_type == r2fft_pkg::REQ_RUN) begin
          state_next = S_SW_RDI;
          pos_next   = '0;
          stage_next = 4'd1;
        end
      end
      S_SW_RDI: begin
        rd_addr = pos;
        if (rev > pos) state_next = S_SW_RDR;
        else if (pos == last_pos) begin
          state_next = S_BF_RDP;
          stage_next = 4'd1;
          bfc_next   = '0;
        end else pos_next = pos + AW'(1);
      end
      S_SW_RDR: begin
        rd_addr    = rev;
        state_next = S_SW_WRI;
      end
      S_SW_WRI: begin
        wr_en      = 1'b1;
        wr_addr    = pos;
        wr_data    = rd_q;
        state_next = S_SW_WRR;
      end
      S_SW_WRR: begin
        wr_en   = 1'b1;
        wr_addr = rev;
        wr_data = hold;
        if (pos == last_pos) begin
          state_next = S_BF_RDP;
          stage_next = 4'd1;
          bfc_next   = '0;
        end else begin
          state_next = S_SW_RDI;
          pos_next   = pos + AW'(1);
        end
      end
      S_BF_RDP: begin
        rd_addr    = p_addr;
        state_next = S_BF_RDQ;
      end
      S_BF_RDQ: begin
        rd_addr    = q_addr;
        state_next = S_BF_MUL;
      end
      S_BF_MUL: state_next = S_BF_ADD;
      S_BF_ADD: begin
        wr_en      = 1'b1;
        wr_addr    = p_addr;
        wr_data    = bf_a;
        state_next = S_BF_WRQ;
      end
      S_BF_WRQ: begin
        wr_en      = 1'b1;
        wr_addr    = q_addr;
        wr_data    = b_reg;
        state_next = S_BF_RDP;
        if (bfc == last_bfc) begin
          bfc_next = '0;
          if (stage == len_l) state_next = S_IDLE;
          else stage_next = stage + 4'd1;
        end else bfc_next = bfc + (AW-1)'(1);
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      log2_points <= 4'd10;
      len_l       <= 4'd10;
      pos         <= '0;
      bfc         <= '0;
      stage       <= 4'd1;
      bin_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      bfc       <= bfc_next;
      stage     <= stage_next;
      bin_valid <= accept && req_type == r2fft_pkg::REQ_READ;
      if (log2_we) log2_points <= log2_wdata;
      if (accept && req_type == r2fft_pkg::REQ_RUN) len_l <= eff_l;
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // payload holding registers and twiddle rom read
  always_ff @(posedge clk) begin
    tw_re_q   <= TW_RE[tw_full[AW-2:0]];
    tw_im_q   <= TW_IM[tw_full[AW-2:0]];
    bin_index <= index;
    if (state == S_SW_RDR) hold  <= rd_q;
    if (state == S_BF_RDQ) u_reg <= rd_q;
    if (state == S_BF_ADD) b_reg <= bf_b;
  end

  r2fft_bfly u_bfly (
    .clk  (clk),
    .x    (rd_q),
    .w_re (tw_re_q),
    .w_im (tw_im_q),
    .u    (u_reg),
    .a    (bf_a),
    .b    (bf_b)
  );

  assign bin_real = rd_q.re;
  assign bin_imag = rd_q.im;

  // checks
  `FFT_ASSERT_NEXT(a_read_result, accept && req_type == r2fft_pkg::REQ_READ, bin_valid)
  `FFT_ASSERT_SAME(a_result_idle, bin_valid, !$past(busy))
  `FFT_ASSERT_SAME(a_run_writes, busy && wr_en, state == S_SW_WRI || state == S_SW_WRR || state == S_BF_ADD || state == S_BF_WRQ)
  `FFT_ASSERT_SAME(a_stage_range, busy, stage <= len_l && stage >= 4'd1)

endmodule

// ===== src/r2fft_bfly.sv =====
// butterfly datapath: registered complex multiply, then add and subtract
// depends on r2fft_pkg
module r2fft_bfly (
  input  logic                 clk,
  input  r2fft_pkg::cplx_t     x,
  input  logic signed [r2fft_pkg::TW_W-1:0] w_re,
  input  logic signed [r2fft_pkg::TW_W-1:0] w_im,
  input  r2fft_pkg::cplx_t     u,
  output r2fft_pkg::cplx_t     a,
  output r2fft_pkg::cplx_t     b
);

  logic signed [r2fft_pkg::PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [r2fft_pkg::PROD_W:0]   s_re, s_im;
  logic signed [r2fft_pkg::DATA_W-1:0] t_re, t_im;

  // four partial products, registered
  always_ff @(posedge clk) begin
    p_rr <= w_re * x.re;
    p_ii <= w_im * x.im;
    p_ri <= w_re * x.im;
    p_ir <= w_im * x.re;
  end

  // sums, truncating shift, wrap to data width
  always_comb begin
    s_re = (r2fft_pkg::PROD_W+1)'(p_rr) - (r2fft_pkg::PROD_W+1)'(p_ii);
    s_im = (r2fft_pkg::PROD_W+1)'(p_ri) + (r2fft_pkg::PROD_W+1)'(p_ir);
    t_re = s_re[r2fft_pkg::TW_W-1 +: r2fft_pkg::DATA_W];
    t_im = s_im[r2fft_pkg::TW_W-1 +: r2fft_pkg::DATA_W];
    a.re = u.re + t_re;
    a.im = u.im + t_im;
    b.re = u.re - t_re;
    b.im = u.im - t_im;
  end

endmodule
